/* rtl/rob_pkg.sv */
// shared types and constants for the row occupancy and barycenter block
package rob_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int QUEUE_DEPTH   = 2;
    localparam int PCT           = 100;
    localparam int RES_W         = 7;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } pix_t;

    typedef struct packed {
        logic [RES_W-1:0] occupancy;
        logic [RES_W-1:0] center;
        logic             center_valid;
    } res_t;

endpackage

/* rtl/rob_front.sv */
// pixel front end: column tracking and per-row white statistics
module rob_front #(
    parameter int MAX_WIDTH = rob_pkg::DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int IW = $clog2(MAX_WIDTH),
    localparam int SW = 2 * CW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  rob_pkg::pix_t pix_data,
    input  logic          full,
    output logic          push,
    output logic [IW-1:0] rec_first,
    output logic [IW-1:0] rec_last,
    output logic [CW-1:0] rec_count,
    output logic [SW-1:0] rec_sum
);
    import rob_pkg::*;

    logic [CW-1:0] column_reg, column_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] last_reg, last_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          seen_reg, seen_next;
    logic          accept;
    logic          in_range;
    logic          white;
    logic [IW-1:0] col_idx;

    assign pix_stall = full;
    assign accept    = pix_valid && !full;
    assign in_range  = column_reg < CW'(MAX_WIDTH);
    assign white     = in_range && (pix_data.pixel != 8'd0);
    assign col_idx   = column_reg[IW-1:0];

    always_comb
    begin
        column_next = in_range ? column_reg + CW'(1) : column_reg;
        first_next  = (white && !seen_reg) ? col_idx : first_reg;
        last_next   = white ? col_idx : last_reg;
        count_next  = count_reg + CW'(white);
        sum_next    = sum_reg + (white ? SW'(column_reg) : SW'(0));
        seen_next   = seen_reg || white;
    end

    // the row record carries the statistics including the row's last pixel
    assign push      = accept && pix_data.row_end;
    assign rec_first = first_next;
    assign rec_last  = last_next;
    assign rec_count = count_next;
    assign rec_sum   = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            seen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (pix_data.row_end)
            begin
                column_reg <= '0;
                first_reg  <= '0;
                last_reg   <= '0;
                count_reg  <= '0;
                sum_reg    <= '0;
                seen_reg   <= 1'b0;
            end
            else
            begin
                column_reg <= column_next;
                first_reg  <= first_next;
                last_reg   <= last_next;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

/* rtl/rob_queue.sv */
// short first-in first-out queue of row records
module rob_queue #(
    parameter int W     = 8,
    parameter int DEPTH = rob_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         full,
    output logic         valid,
    output logic [W-1:0] rdata
);
    import rob_pkg::*;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [NW-1:0] fill_reg;

    assign full  = fill_reg == NW'(DEPTH);
    assign valid = fill_reg != '0;
    assign rdata = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

/* rtl/rob_div.sv */
// restoring divider, one quotient bit per cycle
module rob_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    localparam int KW = $clog2(NW)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import rob_pkg::*;

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    assign rem_sh  = {rem_reg, q_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign done    = done_reg;
    assign quo     = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            q_reg    <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so DW bits hold it
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg + KW'(1);
            if (cnt_reg == KW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

/* rtl/rob_back.sv */
// row back end: occupancy and barycenter through a shared serial divider
module rob_back #(
    parameter int MAX_WIDTH = rob_pkg::DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int IW = $clog2(MAX_WIDTH),
    localparam int SW = 2 * CW,
    localparam int RW = 2 * IW + CW + SW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  logic [RW-1:0] q_data,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_stall,
    output rob_pkg::res_t res_data
);
    import rob_pkg::*;

    localparam int NW = SW + RES_W;

    typedef enum logic [2:0] {
        IDLE,
        OFFS,
        SCALE,
        OCC,
        QUO,
        CTR,
        HOLD
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     first_reg;
    logic [IW-1:0]     last_reg;
    logic [CW-1:0]     count_reg;
    logic [SW-1:0]     sum_reg;
    logic [SW-1:0]     offs_reg;
    logic [NW-1:0]     scaled_reg;
    logic [RES_W-1:0]  occ_reg;
    logic              div_start_reg;
    logic [NW-1:0]     div_num_reg;
    logic [CW-1:0]     div_den_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic [IW-1:0]     h_first;
    logic [IW-1:0]     h_last;
    logic [CW-1:0]     h_count;
    logic [SW-1:0]     h_sum;
    logic              h_ok;
    logic [CW-1:0]     span;
    logic              div_done;
    logic [NW-1:0]     div_quo;

    assign {h_first, h_last, h_count, h_sum} = q_data;
    assign h_ok      = (h_count >= CW'(2)) && (h_last > h_first);
    assign span      = CW'(last_reg - first_reg);
    assign pop       = (state_reg == IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    rob_div #(
        .NW(NW),
        .DW(CW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start_reg),
        .num  (div_num_reg),
        .den  (div_den_reg),
        .done (div_done),
        .quo  (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            offs_reg      <= '0;
            scaled_reg    <= '0;
            occ_reg       <= '0;
            div_start_reg <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (q_valid)
                    begin
                        first_reg <= h_first;
                        last_reg  <= h_last;
                        count_reg <= h_count;
                        sum_reg   <= h_sum;
                        if (h_ok)
                        begin
                            state_reg <= OFFS;
                        end
                        else
                        begin
                            // under two whites: zero result, no barycenter
                            res_reg       <= '0;
                            res_valid_reg <= 1'b1;
                            state_reg     <= HOLD;
                        end
                    end
                end
                OFFS:
                begin
                    // sum of offsets from the leftmost white
                    offs_reg  <= sum_reg - SW'(count_reg * first_reg);
                    state_reg <= SCALE;
                end
                SCALE:
                begin
                    scaled_reg    <= NW'(offs_reg) * NW'(PCT);
                    div_start_reg <= 1'b1;
                    div_num_reg   <= NW'(count_reg - CW'(1)) * NW'(PCT);
                    div_den_reg   <= span;
                    state_reg     <= OCC;
                end
                OCC:
                begin
                    if (div_done)
                    begin
                        occ_reg       <= div_quo[RES_W-1:0];
                        div_start_reg <= 1'b1;
                        div_num_reg   <= scaled_reg;
                        div_den_reg   <= count_reg;
                        state_reg     <= QUO;
                    end
                end
                QUO:
                begin
                    if (div_done)
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= div_quo;
                        div_den_reg   <= span;
                        state_reg     <= CTR;
                    end
                end
                CTR:
                begin
                    if (div_done)
                    begin
                        res_reg.occupancy    <= occ_reg;
                        res_reg.center       <= div_quo[RES_W-1:0];
                        res_reg.center_valid <= 1'b1;
                        res_valid_reg        <= 1'b1;
                        state_reg            <= HOLD;
                    end
                end
                HOLD:
                begin
                    if (!res_stall)
                    begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/row_occupancy_barycenter.sv */
// top level of the row occupancy and barycenter block
// Pixels of a row are taken one per cycle; the front end keeps the column,
// the extreme white columns, the white count and the column sum, and on the
// pixel flagged row_end it pushes one row record into a two-entry queue. The
// back end turns each record of a row with at least two whites into a
// result with three divisions on a single restoring divider that produces
// one quotient bit per cycle; a row with fewer whites gets a zero result
// with no barycenter. Pixel input stalls only while the queue is full,
// which happens when rows end faster than the back end retires them.
module row_occupancy_barycenter #(
    parameter int MAX_WIDTH = rob_pkg::DEF_MAX_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  rob_pkg::pix_t pix_data,
    output logic          res_valid,
    input  logic          res_stall,
    output rob_pkg::res_t res_data
);
    import rob_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int IW = $clog2(MAX_WIDTH);
    localparam int SW = 2 * CW;
    localparam int RW = 2 * IW + CW + SW;

    logic          full;
    logic          push;
    logic          pop;
    logic          q_valid;
    logic [RW-1:0] q_data;
    logic [IW-1:0] rec_first;
    logic [IW-1:0] rec_last;
    logic [CW-1:0] rec_count;
    logic [SW-1:0] rec_sum;

    rob_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_data (pix_data),
        .full     (full),
        .push     (push),
        .rec_first(rec_first),
        .rec_last (rec_last),
        .rec_count(rec_count),
        .rec_sum  (rec_sum)
    );

    rob_queue #(
        .W    (RW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata({rec_first, rec_last, rec_count, rec_sum}),
        .pop  (pop),
        .full (full),
        .valid(q_valid),
        .rdata(q_data)
    );

    rob_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data)
    );

endmodule
